// ----- hdl/tce_pkg.sv -----
// Shared types, codes and default sizes of the text console character engine.
package tce_pkg;

   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 4;

   localparam int CELL_W     = 16;
   localparam int LOC_CALC_W = 12;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BLANK     = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_location;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

endpackage

// ----- hdl/tce_screen_ram.sv -----
// Single-port screen cell memory with registered read data.
module tce_screen_ram #(
   parameter int DEPTH = tce_pkg::ROWS_DEF * tce_pkg::COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [$clog2(DEPTH)-1:0]      addr,
   input  logic [tce_pkg::CELL_W-1:0]    wdata,
   output logic [tce_pkg::CELL_W-1:0]    rdata
);

   logic [tce_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tce_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/tce_sequencer.sv -----
// Cursor state, command sequencer and fill sweeps over the screen memory.
module tce_sequencer #(
   parameter int COLUMNS  = tce_pkg::COLUMNS_DEF,
   parameter int ROWS     = tce_pkg::ROWS_DEF,
   parameter int TAB_STOP = tce_pkg::TAB_STOP_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [1:0]                           req_opcode,
   input  logic [7:0]                           req_char_code,
   input  logic [4:0]                           req_read_row,
   input  logic [6:0]                           req_read_column,
   input  logic [7:0]                           attr,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output tce_pkg::rsp_type                     rsp,
   output logic                                 mem_we,
   output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_addr,
   output logic [tce_pkg::CELL_W-1:0]           mem_wdata,
   input  logic [tce_pkg::CELL_W-1:0]           mem_rdata
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(TAB_STOP);
   localparam int TW    = $clog2(COLUMNS + TAB_STOP + 1);
   localparam int LW    = tce_pkg::LOC_CALC_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_READ} state_type;

   state_type               state_ff;
   logic [CW-1:0]           col_ff;
   logic [RW-1:0]           row_ff;
   logic [RW-1:0]           top_ff;
   logic [PW-1:0]           phase_ff;
   logic [AW-1:0]           sweep_addr_ff;
   logic [AW-1:0]           sweep_last_ff;
   logic [tce_pkg::CELL_W-1:0] fill_ff;
   logic                    resp_pend_ff;
   logic                    rsp_valid_ff;
   tce_pkg::rsp_type        rsp_ff;

   logic                    accept;
   logic                    is_put;
   logic [CW:0]             col_inc;
   logic                    at_end;
   logic [TW-1:0]           tab_col;
   logic                    tab_wrap;
   logic                    last_row;
   logic [RW-1:0]           top_inc;
   logic [PW-1:0]           phase_inc;
   logic [PW-1:0]           phase_dec;
   logic [CW-1:0]           col_in;
   logic [RW-1:0]           row_in;
   logic [RW-1:0]           top_in;
   logic [PW-1:0]           phase_in;
   logic                    printable;
   logic                    new_line;
   logic                    scroll;
   logic                    is_read;
   logic [RW-1:0]           sel_row;
   logic [CW-1:0]           sel_col;
   logic [RW:0]             prow_sum;
   logic [RW-1:0]           prow;
   logic [AW-1:0]           cell_addr;
   logic [AW-1:0]           scroll_base;
   logic                    read_in_range;
   logic [LW-1:0]           loc_full;
   tce_pkg::rsp_type        rsp_now;

   assign accept    = start && (state_ff == ST_IDLE);
   assign is_put    = accept && (req_opcode == tce_pkg::OP_PUT);
   assign is_read   = req_opcode == tce_pkg::OP_READ;

   assign col_inc   = (CW+1)'(col_ff) + (CW+1)'(1);
   assign at_end    = col_inc >= (CW+1)'(COLUMNS);
   assign tab_col   = TW'(col_ff) + TW'(TAB_STOP) - TW'(phase_ff);
   assign tab_wrap  = tab_col >= TW'(COLUMNS);
   assign last_row  = row_ff == RW'(ROWS - 1);
   assign top_inc   = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + RW'(1);
   assign phase_inc = (phase_ff == PW'(TAB_STOP - 1)) ? '0 : phase_ff + PW'(1);
   assign phase_dec = (phase_ff == '0) ? PW'(TAB_STOP - 1) : phase_ff - PW'(1);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      top_in    = top_ff;
      phase_in  = phase_ff;
      printable = 1'b0;
      new_line  = 1'b0;
      scroll    = 1'b0;
      if (is_put) begin
         case (req_char_code)
            tce_pkg::CH_BACKSPACE: begin
               if (col_ff != '0) begin
                  col_in   = col_ff - CW'(1);
                  phase_in = phase_dec;
               end
            end
            tce_pkg::CH_TAB: begin
               if (tab_wrap) begin
                  new_line = 1'b1;
               end else begin
                  col_in   = tab_col[CW-1:0];
                  phase_in = '0;
               end
            end
            tce_pkg::CH_NEWLINE: begin
               new_line = 1'b1;
            end
            tce_pkg::CH_RETURN: begin
               col_in = col_ff;
            end
            default: begin
               printable = 1'b1;
               if (at_end) begin
                  new_line = 1'b1;
               end else begin
                  col_in   = col_inc[CW-1:0];
                  phase_in = phase_inc;
               end
            end
         endcase
         if (new_line) begin
            col_in   = '0;
            phase_in = '0;
            if (last_row) begin
               scroll = 1'b1;
               top_in = top_inc;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
      end
   end

   // Map a screen row to its physical row through the scroll offset.
   assign sel_row   = is_read ? req_read_row[RW-1:0] : row_ff;
   assign sel_col   = is_read ? req_read_column[CW-1:0] : col_ff;
   assign prow_sum  = (RW+1)'(sel_row) + (RW+1)'(top_ff);
   assign prow      = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                                  : prow_sum[RW-1:0];
   assign cell_addr   = AW'(prow) * AW'(COLUMNS) + AW'(sel_col);
   assign scroll_base = AW'(top_ff) * AW'(COLUMNS);
   assign read_in_range = ({1'b0, req_read_row} < 6'(ROWS)) &&
                          ({1'b0, req_read_column} < 8'(COLUMNS));

   assign mem_we    = (state_ff == ST_SWEEP) || printable;
   assign mem_addr  = (state_ff == ST_SWEEP) ? sweep_addr_ff : cell_addr;
   assign mem_wdata = (state_ff == ST_SWEEP) ? fill_ff : {attr, req_char_code};

   assign loc_full = LW'(row_in) * LW'(COLUMNS) + LW'(col_in);

   always_comb begin
      rsp_now.cursor_column   = 7'(col_in);
      rsp_now.cursor_row      = 5'(row_in);
      rsp_now.cursor_location = loc_full[10:0];
      rsp_now.cell_char       = (state_ff == ST_READ) ? mem_rdata[7:0] : 8'd0;
      rsp_now.cell_attr       = (state_ff == ST_READ) ? mem_rdata[15:8] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         sweep_last_ff <= AW'(CELLS - 1);
         fill_ff       <= {tce_pkg::RESET_ATTR, tce_pkg::CH_BLANK};
         resp_pend_ff  <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         top_ff        <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_opcode)
                     tce_pkg::OP_PUT: begin
                        col_ff   <= col_in;
                        row_ff   <= row_in;
                        top_ff   <= top_in;
                        phase_ff <= phase_in;
                        if (scroll) begin
                           sweep_addr_ff <= scroll_base;
                           sweep_last_ff <= scroll_base + AW'(COLUMNS - 1);
                           fill_ff       <= {attr, tce_pkg::CH_BLANK};
                           resp_pend_ff  <= 1'b1;
                           state_ff      <= ST_SWEEP;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= rsp_now;
                        end
                     end
                     tce_pkg::OP_CLEAR: begin
                        col_ff        <= '0;
                        row_ff        <= '0;
                        top_ff        <= '0;
                        phase_ff      <= '0;
                        sweep_addr_ff <= '0;
                        sweep_last_ff <= AW'(CELLS - 1);
                        fill_ff       <= {attr, tce_pkg::CH_BLANK};
                        resp_pend_ff  <= 1'b1;
                        state_ff      <= ST_SWEEP;
                     end
                     tce_pkg::OP_READ: begin
                        if (read_in_range) begin
                           state_ff <= ST_READ;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= rsp_now;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= rsp_now;
                     end
                  endcase
               end
            end
            ST_SWEEP: begin
               if (sweep_addr_ff == sweep_last_ff) begin
                  state_ff     <= ST_IDLE;
                  resp_pend_ff <= 1'b0;
                  if (resp_pend_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= rsp_now;
                  end
               end else begin
                  sweep_addr_ff <= sweep_addr_ff + AW'(1);
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= rsp_now;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hdl/text_console_character_engine.sv -----
// Top level of the text console character engine: attribute register and screen store.
//
// Usage:
//  - Command channel: drive start with req_opcode, req_char_code, req_read_row
//    and req_read_column; a beat is taken at a rising edge with start high and
//    busy low. busy stays high while a command is still at work.
//  - Result channel: rsp_valid pulses for exactly one cycle with the cursor
//    after the command and, for a read, the cell character and attribute.
//    The receiver cannot stall; every result must be taken in its cycle.
//  - csr_write_enable / csr_write_data write the attribute byte used for
//    printed and blanked cells. Write it only while the block is idle.
//  - Response path, set by the single port of the screen memory: a put, control
//    byte, off-screen read or unused opcode answers in the cycle after acceptance;
//    an on-screen read passes through ST_READ (one registered memory read); a wrap or
//    line feed off the last row blanks one row before it answers; a clear
//    sweeps every cell before it answers.
//  - Reset (synchronous, active high) homes the cursor and runs a fill pass over
//    every cell, writing blank cells with attribute 0x07; busy is
//    high for its length and no result is given for it.
//  - Scrolling moves only the physical row offset; no cells are copied.
module text_console_character_engine #(
   parameter int COLUMNS  = tce_pkg::COLUMNS_DEF,
   parameter int ROWS     = tce_pkg::ROWS_DEF,
   parameter int TAB_STOP = tce_pkg::TAB_STOP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_column,
   output logic        rsp_valid,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_location,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attr,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   // Attribute byte; resets to light gray on black.
   logic [7:0] attr_ff;

   logic                       mem_we;
   logic [AW-1:0]              mem_addr;
   logic [tce_pkg::CELL_W-1:0] mem_wdata;
   logic [tce_pkg::CELL_W-1:0] mem_rdata;
   tce_pkg::rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tce_pkg::RESET_ATTR;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   // Sequencer: decode the beat, advance the cursor, run blank sweeps.
   tce_sequencer #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .req_read_row    (req_read_row),
      .req_read_column (req_read_column),
      .attr            (attr_ff),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp             (rsp),
      .mem_we          (mem_we),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .mem_rdata       (mem_rdata)
   );

   // Screen store: character in the low byte, attribute in the high byte.
   tce_screen_ram #(
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_cursor_column   = rsp.cursor_column;
   assign rsp_cursor_row      = rsp.cursor_row;
   assign rsp_cursor_location = rsp.cursor_location;
   assign rsp_cell_char       = rsp.cell_char;
   assign rsp_cell_attr       = rsp.cell_attr;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the text console engine: random command beats against a screen predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tce_pkg::*;

   localparam int COLUMNS  = COLUMNS_DEF;
   localparam int ROWS     = ROWS_DEF;
   localparam int TAB_STOP = TAB_STOP_DEF;

   // Opcode 3 is unused by the block; it must answer with the cursor and zero cell fields.
   localparam logic [1:0] OP_NONE = 2'd3;

   // Worst case stays below this even if every beat were a full clear with a long gap.
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PHASE_ITEMS   = 100;
   localparam int RANDOM_PHASES = 6;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_column;
   } console_cmd_t;

   // Block ports; every input holds a known value from time zero.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode       = OP_PUT;
   logic [7:0]  req_char_code    = 8'd0;
   logic [4:0]  req_read_row     = 5'd0;
   logic [6:0]  req_read_column  = 7'd0;
   logic        rsp_valid;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_location;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_attr;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data   = 8'd0;

   // Stimulus and scoreboard state.
   console_cmd_t command_queue[$];
   rsp_type      expected_screen_reports[$];
   bit           beat_taken   = 1'b0;
   bit           gaps_allowed = 1'b1;
   int           idle_left    = 0;
   int           queued_total = 0;
   int           counted_beats = 0;
   int           answered     = 0;
   int           fail_count   = 0;
   int           cycle_count  = 0;
   int           attr_writes  = 0;

   // Predictor state: the screen store as physical rows, cursor, scroll offset, attribute.
   logic [15:0]  screen_model [0:ROWS*COLUMNS-1];
   int unsigned  cur_col;
   int unsigned  cur_row;
   int unsigned  top_offset;
   logic [7:0]   attr_model;
   int           read_count   = 0;
   int           scroll_count = 0;
   int           clear_count  = 0;

   text_console_character_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .TAB_STOP(TAB_STOP)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_column    (req_read_column),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_location(rsp_cursor_location),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Screen predictor
   // ---------------------------------------------------------------------------------------

   // Screen row r lives in physical row (r + offset) mod ROWS; a scroll just bumps the offset.
   function automatic int unsigned cell_index(int unsigned row, int unsigned col);
      return ((row + top_offset) % ROWS) * COLUMNS + col;
   endfunction

   function automatic void blank_row(int unsigned prow);
      for (int c = 0; c < COLUMNS; c++) begin
         screen_model[prow * COLUMNS + c] = {attr_model, CH_BLANK};
      end
   endfunction

   // Move to column 0 of the next line; from the last row, recycle the old top row as the
   // new bottom line and blank it with the current attribute.
   function automatic void advance_line();
      int unsigned old_top;
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
         old_top    = top_offset % ROWS;
         top_offset = (old_top + 1) % ROWS;
         blank_row(old_top);
         cur_row    = ROWS - 1;
         scroll_count++;
      end else begin
         cur_row++;
      end
   endfunction

   // Apply one accepted command to the model and return the report the block owes for it.
   function automatic rsp_type apply_console_command(console_cmd_t cmd);
      rsp_type     report;
      int unsigned next_col;
      logic [15:0] cell_word;
      report = '0;
      case (cmd.opcode)
         OP_PUT: begin
            case (cmd.char_code)
               CH_BACKSPACE: begin
                  // Stop at column 0; the backspace never leaves the line.
                  if (cur_col > 0) cur_col--;
               end
               CH_TAB: begin
                  // A tab that hits the line end wraps exactly like a printed byte.
                  next_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
                  if (next_col >= COLUMNS) advance_line();
                  else cur_col = next_col;
               end
               CH_NEWLINE: begin
                  advance_line();
               end
               CH_RETURN: begin
                  // Carriage return is dropped; the cursor is reported unchanged.
               end
               default: begin
                  screen_model[cell_index(cur_row, cur_col)] = {attr_model, cmd.char_code};
                  if (cur_col + 1 >= COLUMNS) advance_line();
                  else cur_col++;
               end
            endcase
         end
         OP_CLEAR: begin
            for (int r = 0; r < ROWS; r++) begin
               blank_row(r);
            end
            top_offset = 0;
            cur_col    = 0;
            cur_row    = 0;
            clear_count++;
         end
         OP_READ: begin
            // Reads off the screen return zero cells and change nothing.
            if (cmd.read_row < ROWS && cmd.read_column < COLUMNS) begin
               cell_word        = screen_model[cell_index(cmd.read_row, cmd.read_column)];
               report.cell_char = cell_word[7:0];
               report.cell_attr = cell_word[15:8];
               read_count++;
            end
         end
         default: begin
            // Unused opcode: report the cursor only.
         end
      endcase
      report.cursor_column   = 7'(cur_col);
      report.cursor_row      = 5'(cur_row);
      report.cursor_location = 11'(cur_row * COLUMNS + cur_col);
      return report;
   endfunction

   function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   // Queue one command beat. Carriage returns and the unused opcode do not count toward the
   // phase size, since the block merely ignores them.
   task automatic add_beat(logic [1:0] op, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
      command_queue.push_back('{op, ch, row, col});
      queued_total++;
      if (op != OP_NONE && !(op == OP_PUT && ch == CH_RETURN)) counted_beats++;
   endtask

   // Printable-heavy byte that the block prints rather than interprets.
   function automatic logic [7:0] random_glyph();
      logic [7:0] ch;
      do begin
         ch = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                          : 8'($urandom_range(0, 255));
      end while (ch == CH_BACKSPACE || ch == CH_TAB || ch == CH_NEWLINE || ch == CH_RETURN);
      return ch;
   endfunction

   // Mostly well-formed text traffic (runs of text, line feeds, tabs, backspaces and read-back
   // bursts) with a sprinkle of noise: stray bytes, returns, unused opcodes, off-screen reads
   // and the odd clear.
   task automatic gen_random_phase(int target);
      int first;
      int kind;
      int n;
      first = counted_beats;
      while (counted_beats - first < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // Occasional long runs so that text wraps at the line end.
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 85) : $urandom_range(1, 30);
            repeat (n) add_beat(OP_PUT, random_glyph(), 5'($urandom_range(0, 31)),
                                7'($urandom_range(0, 127)));
         end else if (kind < 52) begin
            n = $urandom_range(1, 6);
            repeat (n) add_beat(OP_PUT, CH_NEWLINE, 5'($urandom_range(0, 31)),
                                7'($urandom_range(0, 127)));
         end else if (kind < 60) begin
            n = $urandom_range(1, 22);
            repeat (n) add_beat(OP_PUT, CH_TAB, 5'($urandom_range(0, 31)),
                                7'($urandom_range(0, 127)));
         end else if (kind < 66) begin
            n = $urandom_range(1, 8);
            repeat (n) add_beat(OP_PUT, CH_BACKSPACE, 5'($urandom_range(0, 31)),
                                7'($urandom_range(0, 127)));
         end else if (kind < 85) begin
            // Bias reads toward the bottom rows, where fresh text and scrolled lines sit.
            n = $urandom_range(1, 6);
            repeat (n) add_beat(OP_READ, 8'($urandom_range(0, 255)),
                                5'(($urandom_range(0, 2) != 0)
                                   ? $urandom_range(ROWS - 3, ROWS - 1)
                                   : $urandom_range(0, ROWS - 1)),
                                7'($urandom_range(0, COLUMNS - 1)));
         end else if (kind < 98) begin
            case ($urandom_range(0, 5))
               0: add_beat(OP_PUT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                           7'($urandom_range(0, 127)));
               1: add_beat(OP_NONE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                           7'($urandom_range(0, 127)));
               2: add_beat(OP_READ, 8'($urandom_range(0, 255)), 5'($urandom_range(ROWS, 31)),
                           7'($urandom_range(0, 127)));
               3: add_beat(OP_READ, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                           7'($urandom_range(COLUMNS, 127)));
               4: add_beat(OP_PUT, CH_RETURN, 5'($urandom_range(0, 31)),
                           7'($urandom_range(0, 127)));
               default: add_beat(OP_READ, 8'($urandom_range(0, 255)),
                                 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            endcase
         end else begin
            add_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
         end
      end
   endtask

   // Hold until every queued beat has been answered and the block drops busy.
   task automatic wait_until_idle();
      while (answered != queued_total || busy !== 1'b0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      @(negedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      attr_writes++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: present the next beat at the falling edge; hold it until taken.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      console_cmd_t cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         // Maybe leave a gap right after a beat, so gaps land while the block is at work.
         if (start && gaps_allowed && $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(1, 13);
         end
         beat_taken = 1'b0;
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (command_queue.size() > 0) begin
            cmd = command_queue.pop_front();
            req_opcode      <= cmd.opcode;
            req_char_code   <= cmd.char_code;
            req_read_row    <= cmd.read_row;
            req_read_column <= cmd.read_column;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: at the rising edge, predict accepted beats and check each result strobe.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      console_cmd_t cmd;
      rsp_type      want;
      if (!reset) begin
         // Track the attribute register; this bench writes it only while the block is idle.
         if (csr_write_enable) attr_model = csr_write_data;
         if (start && !busy) begin
            cmd.opcode      = req_opcode;
            cmd.char_code   = req_char_code;
            cmd.read_row    = req_read_row;
            cmd.read_column = req_read_column;
            expected_screen_reports.push_back(apply_console_command(cmd));
            beat_taken = 1'b1;
         end
         if (rsp_valid) begin
            if (expected_screen_reports.size() == 0) begin
               $error("result beat with nothing outstanding");
               fail_count++;
            end else begin
               want = expected_screen_reports.pop_front();
               check_field("cursor_column", want.cursor_column, rsp_cursor_column);
               check_field("cursor_row", want.cursor_row, rsp_cursor_row);
               check_field("cursor_location", want.cursor_location, rsp_cursor_location);
               check_field("cell_char", want.cell_char, rsp_cell_char);
               check_field("cell_attr", want.cell_attr, rsp_cell_attr);
               answered++;
            end
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_console_character_engine: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [7:0] attr_value;

      // Model the post-reset screen: every cell a blank with attribute 0x07.
      for (int i = 0; i < ROWS * COLUMNS; i++) begin
         screen_model[i] = {RESET_ATTR, CH_BLANK};
      end
      cur_col    = 0;
      cur_row    = 0;
      top_offset = 0;
      attr_model = RESET_ATTR;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      // Wait out the fill pass that follows reset.
      wait_until_idle();

      // Directed beats with the reset attribute: reset contents, off-screen reads, the
      // corners, backspace at column 0, returns, the unused opcode, extreme bytes, clear.
      add_beat(OP_READ, 8'h00, 5'd0, 7'd0);
      add_beat(OP_READ, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
      add_beat(OP_READ, 8'h00, 5'(ROWS), 7'd0);
      add_beat(OP_READ, 8'h00, 5'd0, 7'(COLUMNS));
      add_beat(OP_READ, 8'hFF, 5'h1F, 7'h7F);
      add_beat(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);
      add_beat(OP_PUT, CH_RETURN, 5'h1F, 7'h7F);
      add_beat(OP_NONE, 8'hFF, 5'h1F, 7'h7F);
      add_beat(OP_PUT, 8'h00, 5'd0, 7'd0);
      add_beat(OP_PUT, 8'hFF, 5'h1F, 7'h7F);
      add_beat(OP_PUT, 8'h41, 5'd0, 7'd0);
      add_beat(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);
      add_beat(OP_PUT, CH_TAB, 5'd0, 7'd0);
      add_beat(OP_PUT, CH_TAB, 5'd0, 7'd0);
      add_beat(OP_PUT, CH_RETURN, 5'd0, 7'd0);
      add_beat(OP_READ, 8'h00, 5'd0, 7'd0);
      add_beat(OP_READ, 8'h00, 5'd0, 7'd1);
      add_beat(OP_READ, 8'h00, 5'd0, 7'd2);
      add_beat(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
      add_beat(OP_PUT, 8'h7F, 5'd0, 7'd0);
      add_beat(OP_CLEAR, 8'h00, 5'd0, 7'd0);
      add_beat(OP_READ, 8'h00, 5'd1, 7'd0);
      add_beat(OP_READ, 8'h00, 5'd0, 7'd0);
      wait_until_idle();

      // Random phases, each under its own attribute; extremes first, no gaps in the last one.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       attr_value = 8'hFF;
            1:       attr_value = 8'h00;
            3:       attr_value = 8'h80;
            default: attr_value = 8'($urandom_range(0, 255));
         endcase
         write_attribute(attr_value);
         gaps_allowed = (p < RANDOM_PHASES - 1);
         gen_random_phase(PHASE_ITEMS);
         wait_until_idle();
      end

      // Let any stray result show up before closing the books.
      repeat (2 * COLUMNS + 8) @(negedge clock);
      if (expected_screen_reports.size() != 0) begin
         $error("%0d results never arrived", expected_screen_reports.size());
         fail_count++;
      end

      $display("Covered %0d command beats: %0d on-screen reads, %0d scrolls, %0d clears,",
               queued_total, read_count, scroll_count, clear_count);
      $display("under %0d attribute settings after the reset default", attr_writes);
      if (fail_count == 0) begin
         $display("text_console_character_engine: match");
      end else begin
         $display("text_console_character_engine: mismatch");
      end
      $finish;
   end

endmodule
